// ===== sv/cssc_pkg.sv =====
// ----------------------------------------------------------------------------
// cssc_pkg
// Shared constants, register codes and types of the set/slice congruence
// filter.
// ----------------------------------------------------------------------------
package cssc_pkg;

  localparam int ADDRESS_WIDTH    = 52;
  localparam int LINE_OFFSET_BITS = 6;
  localparam int COUNT_WIDTH      = 16;

  localparam int MAX_SET_BITS = 20;
  localparam int SLICE_BITS   = 3;
  localparam int BUDGET_WIDTH = 16;
  localparam int CFG_WIDTH    = 52;
  localparam int CFG_IDX_W    = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VICTIM_ADDRESS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SET_INDEX_BITS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLICE_HASH_BITS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IGNORE_SLICE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CONGRUENT_BUDGET = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OTHER_BUDGET     = 3'd5;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_WIDTH-1:0] data;
  } cfg_wr_t;

  // classified element, front to back
  typedef struct packed {
    logic                    cong;
    logic [MAX_SET_BITS-1:0] eset;
    logic [SLICE_BITS-1:0]   eslice;
    logic                    last;
  } item_t;

  typedef struct packed {
    logic                    is_congruent;
    logic                    is_kept;
    logic [MAX_SET_BITS-1:0] element_set;
    logic [SLICE_BITS-1:0]   element_slice;
    logic [15:0]             congruent_total;
    logic                    all_congruent;
    logic                    nothing_kept;
    logic                    run_done;
  } result_t;

endpackage

// ===== sv/cssc_front.sv =====
// ----------------------------------------------------------------------------
// cssc_front
// Holds the victim and hash configuration and classifies each incoming
// address: set index, slice number and congruence with the victim.
// ----------------------------------------------------------------------------
module cssc_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  cssc_pkg::cfg_wr_t                    cfg,
  input  logic [cssc_pkg::ADDRESS_WIDTH-1:0]   element_address,
  input  logic                                 last_in_run,
  output cssc_pkg::item_t                      item
);

  localparam logic [63:0] HASH_MASK [cssc_pkg::SLICE_BITS] = '{
    64'h0000_001b_5f57_5440,
    64'h0000_002e_b5fa_a880,
    64'h0000_003c_ccc9_3100
  };

  logic [cssc_pkg::ADDRESS_WIDTH-1:0] victim_address;
  logic [4:0]                         set_index_bits;
  logic [1:0]                         slice_hash_bits;
  logic                               ignore_slice;

  function automatic logic [cssc_pkg::MAX_SET_BITS-1:0] set_of(
    input logic [cssc_pkg::ADDRESS_WIDTH-1:0] a,
    input logic [4:0]                         nbits
  );
    logic [4:0]                        b;
    logic [cssc_pkg::MAX_SET_BITS-1:0] m;
    b = (nbits > 5'(cssc_pkg::MAX_SET_BITS)) ? 5'(cssc_pkg::MAX_SET_BITS) : nbits;
    m = (cssc_pkg::MAX_SET_BITS'(1) << b) - cssc_pkg::MAX_SET_BITS'(1);
    return a[cssc_pkg::LINE_OFFSET_BITS +: cssc_pkg::MAX_SET_BITS] & m;
  endfunction

  function automatic logic [cssc_pkg::SLICE_BITS-1:0] slice_of(
    input logic [cssc_pkg::ADDRESS_WIDTH-1:0] a,
    input logic [1:0]                         nbits
  );
    logic [cssc_pkg::SLICE_BITS-1:0] s;
    for (int i = 0; i < cssc_pkg::SLICE_BITS; i++) begin
      s[i] = (2'(i) < nbits) ? ^(a & HASH_MASK[i][cssc_pkg::ADDRESS_WIDTH-1:0]) : 1'b0;
    end
    return s;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      victim_address  <= '0;
      set_index_bits  <= 5'd10;
      slice_hash_bits <= 2'd2;
      ignore_slice    <= 1'b0;
    end else if (cfg.we) begin
      case (cfg.index)
        cssc_pkg::REG_VICTIM_ADDRESS:  victim_address  <= cfg.data[cssc_pkg::ADDRESS_WIDTH-1:0];
        cssc_pkg::REG_SET_INDEX_BITS:  set_index_bits  <= cfg.data[4:0];
        cssc_pkg::REG_SLICE_HASH_BITS: slice_hash_bits <= cfg.data[1:0];
        cssc_pkg::REG_IGNORE_SLICE:    ignore_slice    <= cfg.data[0];
        default: ;
      endcase
    end
  end

  logic [cssc_pkg::MAX_SET_BITS-1:0] v_set;
  logic [cssc_pkg::SLICE_BITS-1:0]   v_slice;

  always_comb begin
    v_set       = set_of(victim_address, set_index_bits);
    v_slice     = slice_of(victim_address, slice_hash_bits);
    item.eset   = set_of(element_address, set_index_bits);
    item.eslice = slice_of(element_address, slice_hash_bits);
    item.last   = last_in_run;
    item.cong   = (item.eset == v_set) && ((item.eslice == v_slice) || ignore_slice);
  end

endmodule

// ===== sv/cssc_queue.sv =====
// ----------------------------------------------------------------------------
// cssc_queue
// Two-entry queue of classified elements between front and back.
// ----------------------------------------------------------------------------
module cssc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  cssc_pkg::item_t wr_item,
  output logic            full,
  input  logic            rd_en,
  output logic            rd_valid,
  output cssc_pkg::item_t rd_item
);

  cssc_pkg::item_t store [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  assign full     = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_item  = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) store[wr_ptr] <= wr_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) wr_ptr <= ~wr_ptr;
      if (rd_en) rd_ptr <= ~rd_ptr;
      count <= count + 2'(wr_en) - 2'(rd_en);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count above depth");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (wr_en && !rd_en) |=> (count == $past(count) + 2'd1))
    else $error("queue count missed a write");

endmodule

// ===== sv/cssc_back.sv =====
// ----------------------------------------------------------------------------
// cssc_back
// Applies budgets and run counters to classified elements and holds the
// result register seen on the output side.
// ----------------------------------------------------------------------------
module cssc_back (
  input  logic              clk,
  input  logic              rst,
  input  cssc_pkg::cfg_wr_t cfg,
  input  logic              q_valid,
  input  cssc_pkg::item_t   q_item,
  output logic              q_pop,
  input  logic              pop,
  output logic              res_valid,
  output cssc_pkg::result_t res
);

  localparam logic [cssc_pkg::COUNT_WIDTH-1:0] COUNT_MAX = '1;

  logic [cssc_pkg::BUDGET_WIDTH-1:0] congruent_budget;
  logic [cssc_pkg::BUDGET_WIDTH-1:0] other_budget;
  logic [cssc_pkg::BUDGET_WIDTH-1:0] congruent_left, congruent_left_next;
  logic [cssc_pkg::BUDGET_WIDTH-1:0] other_left, other_left_next;
  logic [cssc_pkg::COUNT_WIDTH-1:0]  congruent_seen, congruent_seen_next;
  logic                              all_match_flag, all_match_flag_next;
  logic                              any_kept_flag, any_kept_flag_next;
  logic                              kept;

  // take an element whenever the result register is free or being drained
  assign q_pop = q_valid && (!res_valid || pop);

  always_comb begin
    congruent_left_next = congruent_left;
    other_left_next     = other_left;
    congruent_seen_next = congruent_seen;
    all_match_flag_next = all_match_flag;
    kept                = 1'b0;
    if (q_item.cong) begin
      if (congruent_left != '0) begin
        kept                = 1'b1;
        congruent_left_next = congruent_left - cssc_pkg::BUDGET_WIDTH'(1);
      end
      if (congruent_seen != COUNT_MAX)
        congruent_seen_next = congruent_seen + cssc_pkg::COUNT_WIDTH'(1);
    end else begin
      if (other_left != '0) begin
        kept            = 1'b1;
        other_left_next = other_left - cssc_pkg::BUDGET_WIDTH'(1);
      end
      all_match_flag_next = 1'b0;
    end
    any_kept_flag_next = any_kept_flag | kept;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res.is_congruent    <= q_item.cong;
      res.is_kept         <= kept;
      res.element_set     <= q_item.eset;
      res.element_slice   <= q_item.eslice;
      res.congruent_total <= 16'(congruent_seen_next);
      res.all_congruent   <= all_match_flag_next;
      res.nothing_kept    <= q_item.last && !any_kept_flag_next;
      res.run_done        <= q_item.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid        <= 1'b0;
      congruent_budget <= '0;
      other_budget     <= '0;
      congruent_left   <= '0;
      other_left       <= '0;
      congruent_seen   <= '0;
      all_match_flag   <= 1'b1;
      any_kept_flag    <= 1'b0;
    end else begin
      if (q_pop)    res_valid <= 1'b1;
      else if (pop) res_valid <= 1'b0;

      if (q_pop) begin
        if (q_item.last) begin
          congruent_left <= congruent_budget;
          other_left     <= other_budget;
          congruent_seen <= '0;
          all_match_flag <= 1'b1;
          any_kept_flag  <= 1'b0;
        end else begin
          congruent_left <= congruent_left_next;
          other_left     <= other_left_next;
          congruent_seen <= congruent_seen_next;
          all_match_flag <= all_match_flag_next;
          any_kept_flag  <= any_kept_flag_next;
        end
      end

      // budget writes also reload the remaining count
      if (cfg.we && cfg.index == cssc_pkg::REG_CONGRUENT_BUDGET) begin
        congruent_budget <= cfg.data[cssc_pkg::BUDGET_WIDTH-1:0];
        congruent_left   <= cfg.data[cssc_pkg::BUDGET_WIDTH-1:0];
      end
      if (cfg.we && cfg.index == cssc_pkg::REG_OTHER_BUDGET) begin
        other_budget <= cfg.data[cssc_pkg::BUDGET_WIDTH-1:0];
        other_left   <= cfg.data[cssc_pkg::BUDGET_WIDTH-1:0];
      end
    end
  end

  a_none_only_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.nothing_kept) |-> res.run_done)
    else $error("nothing_kept outside end of run");
  a_all_needs_cong: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.is_congruent) |-> !res.all_congruent)
    else $error("all_congruent set on non-congruent element");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !pop) |=> (res_valid && $stable(res)))
    else $error("result changed while waiting");

endmodule

// ===== sv/cache_set_slice_congruence_filter.sv =====
// ----------------------------------------------------------------------------
// cache_set_slice_congruence_filter
// Compares a stream of physical line addresses with a victim line by set
// index and XOR-parity slice hash, keeps elements within per-run budgets and
// reports run statistics.
// ----------------------------------------------------------------------------
// Path: an input transfer is written into the queue, and the result
//   register is loaded from the queue once it is free or being drained.
// Throughput: one element per cycle while results are popped; the front
//   classifier and the back budget stage each handle one element a cycle.
// Reset: synchronous; queue and result register empty, config registers at
//   their defaults (set_index_bits 10, slice_hash_bits 2, others 0), run
//   counters reloaded from the zero budgets.
// ----------------------------------------------------------------------------
module cache_set_slice_congruence_filter (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [cssc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cssc_pkg::CFG_WIDTH-1:0]      cfg_data,
  // element input, queue style
  input  logic                                push,
  output logic                                full,
  input  logic [cssc_pkg::ADDRESS_WIDTH-1:0]  element_address,
  input  logic                                last_in_run,
  // result output, queue style
  output logic                                empty,
  input  logic                                pop,
  output logic                                is_congruent,
  output logic                                is_kept,
  output logic [cssc_pkg::MAX_SET_BITS-1:0]   element_set,
  output logic [cssc_pkg::SLICE_BITS-1:0]     element_slice,
  output logic [15:0]                         congruent_total,
  output logic                                all_congruent,
  output logic                                nothing_kept,
  output logic                                run_done
);

  cssc_pkg::cfg_wr_t cfg;
  cssc_pkg::item_t   f_item;     // classified element from the front
  cssc_pkg::item_t   q_item;     // oldest queued element
  cssc_pkg::result_t res;
  logic              q_valid;
  logic              q_pop;
  logic              res_valid;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // Front: victim/hash config and per-address classification (combinational).
  cssc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .element_address (element_address),
    .last_in_run     (last_in_run),
    .item            (f_item)
  );

  // Decoupling queue; a transfer in happens on push while not full.
  cssc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (push && !full),
    .wr_item  (f_item),
    .full     (full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_item  (q_item)
  );

  // Back: budgets, run counters and the result register.
  cssc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .pop       (pop),
    .res_valid (res_valid),
    .res       (res)
  );

  assign empty           = !res_valid;
  assign is_congruent    = res.is_congruent;
  assign is_kept         = res.is_kept;
  assign element_set     = res.element_set;
  assign element_slice   = res.element_slice;
  assign congruent_total = res.congruent_total;
  assign all_congruent   = res.all_congruent;
  assign nothing_kept    = res.nothing_kept;
  assign run_done        = res.run_done;

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the set/slice congruence filter. A directed table
// walks reset defaults, address and register extremes, slice masking, the
// wide set clamp, ignored register indexes and a mid-run budget reload.
// Random phases with random settings and well-formed runs follow. Every
// result transfer is checked field by field against a bench-side model of
// the filter or, for hand-written rows, against the typed expectation.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // indexes past the last register; writes there must change nothing
  localparam logic [cssc_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [cssc_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic [cssc_pkg::ADDRESS_WIDTH-1:0] ALL_ONES =
    {cssc_pkg::ADDRESS_WIDTH{1'b1}};
  // bit 32 sits only in hash mask 0, so flipping it moves slice bit 0 alone
  localparam logic [cssc_pkg::ADDRESS_WIDTH-1:0] SLICE0_FLIP = 52'h1 << 32;
  // set field for the widest set index, bits 25:6
  localparam logic [cssc_pkg::ADDRESS_WIDTH-1:0] SET_FIELD = 52'h3FF_FFC0;

  localparam logic [cssc_pkg::ADDRESS_WIDTH-1:0] HASH_MASK [3] = '{
    52'h1b5f575440, 52'h2eb5faa880, 52'h3cccc93100
  };

  localparam int RANDOM_PHASES   = 6;
  localparam int ITEMS_PER_PHASE = 72;

  // single-item run that is congruent and keeps nothing (zero budgets)
  localparam cssc_pkg::result_t ALONE_CONGRUENT = '{
    is_congruent:    1'b1,
    is_kept:         1'b0,
    element_set:     '0,
    element_slice:   '0,
    congruent_total: 16'd1,
    all_congruent:   1'b1,
    nothing_kept:    1'b1,
    run_done:        1'b1
  };

  typedef enum logic {ROW_ELEMENT, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e                          kind;
    logic [cssc_pkg::CFG_IDX_W-1:0]     idx;
    logic [cssc_pkg::ADDRESS_WIDTH-1:0] value;   // element address or register data
    logic                               is_last;
    bit                                 typed;   // want below is hand-written
    cssc_pkg::result_t                  want;
  } stim_row_t;

  // --------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               cfg_we = 1'b0;
  logic [cssc_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
  logic [cssc_pkg::CFG_WIDTH-1:0]     cfg_data = '0;
  logic                               push = 1'b0;
  logic                               full;
  logic [cssc_pkg::ADDRESS_WIDTH-1:0] element_address = '0;
  logic                               last_in_run = 1'b0;
  logic                               empty;
  logic                               pop = 1'b0;
  logic                               is_congruent;
  logic                               is_kept;
  logic [cssc_pkg::MAX_SET_BITS-1:0]  element_set;
  logic [cssc_pkg::SLICE_BITS-1:0]    element_slice;
  logic [15:0]                        congruent_total;
  logic                               all_congruent;
  logic                               nothing_kept;
  logic                               run_done;

  cache_set_slice_congruence_filter dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .push            (push),
    .full            (full),
    .element_address (element_address),
    .last_in_run     (last_in_run),
    .empty           (empty),
    .pop             (pop),
    .is_congruent    (is_congruent),
    .is_kept         (is_kept),
    .element_set     (element_set),
    .element_slice   (element_slice),
    .congruent_total (congruent_total),
    .all_congruent   (all_congruent),
    .nothing_kept    (nothing_kept),
    .run_done        (run_done)
  );

  // 12 ns period
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // --------------------------------------------------------------------------
  // Filter model: configuration copy plus per-run counters
  // --------------------------------------------------------------------------
  logic [cssc_pkg::ADDRESS_WIDTH-1:0] victim_line;
  logic [4:0]                         set_bits;
  logic [1:0]                         hash_bits;
  logic                               slice_ignored;
  logic [15:0]                        cong_budget;
  logic [15:0]                        other_budget;
  logic [15:0]                        cong_left;
  logic [15:0]                        other_left;
  logic [15:0]                        cong_seen;
  logic                               all_match;
  logic                               any_kept;

  cssc_pkg::result_t pending_results [$];   // expected results, oldest first
  stim_row_t directed [$];

  int  mismatches = 0;
  int  items_sent = 0;
  int  results_checked = 0;
  int  runs_closed = 0;
  int  congruent_results = 0;
  int  kept_results = 0;
  bit  no_idle = 1'b0;            // suppresses gaps on both sides
  int  pop_stall = 0;

  function automatic logic [cssc_pkg::MAX_SET_BITS-1:0] set_index(
    input logic [cssc_pkg::ADDRESS_WIDTH-1:0] a
  );
    int                                 n;
    logic [cssc_pkg::MAX_SET_BITS-1:0]  m;
    logic [cssc_pkg::ADDRESS_WIDTH-1:0] sh;
    // clamp wide index
    n  = (set_bits > cssc_pkg::MAX_SET_BITS) ? cssc_pkg::MAX_SET_BITS : set_bits;
    m  = (20'd1 << n) - 20'd1;
    sh = a >> cssc_pkg::LINE_OFFSET_BITS;
    return sh[cssc_pkg::MAX_SET_BITS-1:0] & m;
  endfunction

  function automatic logic [cssc_pkg::SLICE_BITS-1:0] slice_hash(
    input logic [cssc_pkg::ADDRESS_WIDTH-1:0] a
  );
    logic [cssc_pkg::SLICE_BITS-1:0] s;
    s = '0;
    for (int i = 0; i < cssc_pkg::SLICE_BITS; i++)
      if (i < hash_bits) s[i] = ^(a & HASH_MASK[i]);
    return s;
  endfunction

  function automatic void start_run();
    cong_left  = cong_budget;
    other_left = other_budget;
    cong_seen  = '0;
    all_match  = 1'b1;
    any_kept   = 1'b0;
  endfunction

  function automatic void apply_register_write(input logic [cssc_pkg::CFG_IDX_W-1:0] idx,
                                               input logic [cssc_pkg::CFG_WIDTH-1:0] data);
    case (idx)
      cssc_pkg::REG_VICTIM_ADDRESS:
        victim_line = data[cssc_pkg::ADDRESS_WIDTH-1:0];
      cssc_pkg::REG_SET_INDEX_BITS:  set_bits      = data[4:0];
      cssc_pkg::REG_SLICE_HASH_BITS: hash_bits     = data[1:0];
      cssc_pkg::REG_IGNORE_SLICE:    slice_ignored = data[0];
      cssc_pkg::REG_CONGRUENT_BUDGET: begin
        cong_budget = data[15:0];
        cong_left   = cong_budget;
      end
      cssc_pkg::REG_OTHER_BUDGET: begin
        other_budget = data[15:0];
        other_left   = other_budget;
      end
      default: ;
    endcase
  endfunction

  // classify one element and advance the run counters
  function automatic cssc_pkg::result_t classify_element(
    input logic [cssc_pkg::ADDRESS_WIDTH-1:0] addr,
    input logic                               is_last
  );
    cssc_pkg::result_t r;
    r = '0;
    r.element_set   = set_index(addr);
    r.element_slice = slice_hash(addr);
    r.is_congruent  = (r.element_set == set_index(victim_line)) &&
                      ((r.element_slice == slice_hash(victim_line)) || slice_ignored);
    if (r.is_congruent) begin
      if (cong_left != 0) begin
        r.is_kept = 1'b1;
        cong_left--;
      end
      if (cong_seen != 16'hFFFF) cong_seen++;   // saturating
    end else begin
      if (other_left != 0) begin
        r.is_kept = 1'b1;
        other_left--;
      end
      all_match = 1'b0;
    end
    if (r.is_kept) any_kept = 1'b1;
    r.nothing_kept    = is_last && !any_kept;
    r.congruent_total = cong_seen;
    r.all_congruent   = all_match;
    r.run_done        = is_last;
    if (is_last) start_run();
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Random helpers
  // --------------------------------------------------------------------------
  // mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [cssc_pkg::ADDRESS_WIDTH-1:0] rand_address();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[cssc_pkg::ADDRESS_WIDTH-1:0];
  endfunction

  // small budgets run out inside a run; zero and full scale are the extremes
  function automatic logic [15:0] pick_budget();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return 16'd0;
    if (r == 3) return 16'hFFFF;
    return 16'($urandom_range(1, 6));
  endfunction

  function automatic void add_write(input logic [cssc_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [cssc_pkg::ADDRESS_WIDTH-1:0] value);
    directed.push_back('{ROW_WRITE, idx, value, 1'b0, 1'b0, '0});
  endfunction

  function automatic void add_element(input logic [cssc_pkg::ADDRESS_WIDTH-1:0] addr,
                                      input logic is_last);
    directed.push_back('{ROW_ELEMENT, '0, addr, is_last, 1'b0, '0});
  endfunction

  // --------------------------------------------------------------------------
  // Driver tasks: inputs change on the falling edge, transfers are seen on
  // the rising edge
  // --------------------------------------------------------------------------
  task automatic send_element(input logic [cssc_pkg::ADDRESS_WIDTH-1:0] addr,
                              input logic is_last,
                              input bit typed, input cssc_pkg::result_t typed_want);
    int                gap;
    cssc_pkg::result_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    push            <= 1'b1;
    element_address <= addr;
    last_in_run     <= is_last;
    do @(posedge clk); while (full);
    // transfer taken at this edge
    predicted = classify_element(addr, is_last);
    pending_results.push_back(typed ? typed_want : predicted);
    items_sent++;
  endtask

  // block idle: push low and every expected result collected
  task automatic drain();
    @(negedge clk);
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [cssc_pkg::CFG_IDX_W-1:0] idx,
                                input logic [cssc_pkg::CFG_WIDTH-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    apply_register_write(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result side: random pop pattern, checked on the rising edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (pop_stall > 0) begin
      pop <= 1'b0;
      pop_stall--;
    end else begin
      pop <= 1'b1;
      pop_stall = pick_gap();
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_results
    cssc_pkg::result_t want;
    if (!rst && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("is_congruent",    want.is_congruent,    is_congruent);
        check_field("is_kept",         want.is_kept,         is_kept);
        check_field("element_set",     want.element_set,     element_set);
        check_field("element_slice",   want.element_slice,   element_slice);
        check_field("congruent_total", want.congruent_total, congruent_total);
        check_field("all_congruent",   want.all_congruent,   all_congruent);
        check_field("nothing_kept",    want.nothing_kept,    nothing_kept);
        check_field("run_done",        want.run_done,        run_done);
        results_checked++;
        if (want.run_done)     runs_closed++;
        if (want.is_congruent) congruent_results++;
        if (want.is_kept)      kept_results++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [cssc_pkg::ADDRESS_WIDTH-1:0] addr;
    logic [cssc_pkg::ADDRESS_WIDTH-1:0] junk;
    int                                 mode;

    // model at reset defaults
    victim_line   = '0;
    set_bits      = 5'd10;
    slice_ignored = 1'b0;
    hash_bits     = 2'd2;
    cong_budget   = '0;
    other_budget  = '0;
    start_run();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // ---- directed table ----
    // reset state: address 0 equals the zero victim, budgets are zero
    directed.push_back('{ROW_ELEMENT, '0, '0, 1'b1, 1'b1, ALONE_CONGRUENT});
    add_element(ALL_ONES, 1'b0);
    add_element('0, 1'b1);
    // all-ones victim, widest set, all three hash bits, tight budgets
    add_write(cssc_pkg::REG_VICTIM_ADDRESS, ALL_ONES);
    add_write(cssc_pkg::REG_SET_INDEX_BITS, 52'd20);
    add_write(cssc_pkg::REG_SLICE_HASH_BITS, 52'd3);
    add_write(cssc_pkg::REG_CONGRUENT_BUDGET, 52'd2);
    add_write(cssc_pkg::REG_OTHER_BUDGET, 52'd1);
    add_element(ALL_ONES, 1'b0);             // kept
    add_element(ALL_ONES, 1'b0);             // kept, budget gone after
    add_element(ALL_ONES, 1'b0);             // congruent, not kept
    add_element('0, 1'b0);                   // other, kept
    add_element('0, 1'b0);                   // other, not kept
    add_element(ALL_ONES ^ SLICE0_FLIP, 1'b1); // same set, other slice
    // slice compare off: the same address turns congruent
    add_write(cssc_pkg::REG_IGNORE_SLICE, 52'd1);
    add_element(ALL_ONES ^ SLICE0_FLIP, 1'b0);
    add_element('0, 1'b1);
    // set index wider than 20 clamps, no slice bits, full budgets
    add_write(cssc_pkg::REG_VICTIM_ADDRESS, '0);
    add_write(cssc_pkg::REG_SET_INDEX_BITS, 52'd31);
    add_write(cssc_pkg::REG_SLICE_HASH_BITS, 52'd0);
    add_write(cssc_pkg::REG_IGNORE_SLICE, 52'd0);
    add_write(cssc_pkg::REG_CONGRUENT_BUDGET, 52'hFFFF);
    add_write(cssc_pkg::REG_OTHER_BUDGET, 52'hFFFF);
    add_write(REG_SPARE_LO, ALL_ONES);       // ignored
    add_write(REG_SPARE_HI, ALL_ONES);       // ignored
    add_element(ALL_ONES, 1'b0);
    add_element(52'h1 << 26, 1'b0);          // just above the clamped set
    add_element(52'h3F, 1'b1);               // line offset only
    // empty set index: every element lands in set 0, slice 0
    add_write(cssc_pkg::REG_SET_INDEX_BITS, 52'd0);
    add_write(cssc_pkg::REG_CONGRUENT_BUDGET, 52'd0);
    add_write(cssc_pkg::REG_OTHER_BUDGET, 52'd0);
    directed.push_back('{ROW_ELEMENT, '0, ALL_ONES, 1'b1, 1'b1, ALONE_CONGRUENT});
    // budget reload in the middle of a run
    add_element(ALL_ONES, 1'b0);
    add_write(cssc_pkg::REG_CONGRUENT_BUDGET, 52'd1);
    add_element('0, 1'b1);

    foreach (directed[k]) begin
      if (directed[k].kind == ROW_WRITE) begin
        drain();
        write_register(directed[k].idx, directed[k].value);
      end else begin
        send_element(directed[k].value, directed[k].is_last,
                     directed[k].typed, directed[k].want);
      end
    end

    // ---- random phases, each with its own settings ----
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain();
      // narrow registers get random upper data bits, which must be dropped
      junk = rand_address();
      write_register(cssc_pkg::REG_VICTIM_ADDRESS, rand_address());
      write_register(cssc_pkg::REG_SET_INDEX_BITS,
                     {junk[51:5], 5'($urandom_range(0, 31))});
      write_register(cssc_pkg::REG_SLICE_HASH_BITS,
                     {junk[51:2], 2'($urandom_range(0, 3))});
      write_register(cssc_pkg::REG_IGNORE_SLICE,
                     {junk[51:1], 1'($urandom_range(0, 1))});
      write_register(cssc_pkg::REG_CONGRUENT_BUDGET, {junk[51:16], pick_budget()});
      write_register(cssc_pkg::REG_OTHER_BUDGET, {junk[51:16], pick_budget()});
      if ($urandom_range(0, 1))
        write_register($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, rand_address());
      no_idle = (phase == 2);   // one phase runs back to back
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        mode = $urandom_range(0, 9);
        addr = rand_address();
        if (mode <= 3)
          addr = (addr & ~SET_FIELD) | (victim_line & SET_FIELD);   // same set
        else if (mode == 4)
          addr = {victim_line[cssc_pkg::ADDRESS_WIDTH-1:cssc_pkg::LINE_OFFSET_BITS],
                  addr[cssc_pkg::LINE_OFFSET_BITS-1:0]};
        else if (mode == 5)
          addr = victim_line ^ (52'h1 << $urandom_range(32, 37));  // slice bits move
        send_element(addr, ($urandom_range(0, 5) == 0), 1'b0, '0);
      end
      no_idle = 1'b0;
    end

    // ---- wrap up ----
    drain();
    repeat (8) @(posedge clk);
    $display("Ran %0d element transfers over %0d finished runs: %0d congruent, %0d kept.",
             items_sent, runs_closed, congruent_results, kept_results);
    $display("Covered: directed table plus %0d random phases; %0d results checked.",
             RANDOM_PHASES, results_checked);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // hang guard, well beyond the slowest legal run
  initial begin : watchdog
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
